// ===== design/btp_pkg.sv =====
// Shared constants and types of the binary trie prefix table.
package btp_pkg;

	localparam int KEY_BITS   = 32;
	localparam int NODE_COUNT = 1024;
	localparam int DATA_BITS  = 32;
	localparam int IDX_BITS   = $clog2(NODE_COUNT);
	localparam int CNT_BITS   = $clog2(NODE_COUNT + 1);
	localparam int DEPTH_BITS = $clog2(KEY_BITS + 1);
	localparam int STK_DEPTH  = KEY_BITS;
	localparam int STK_BITS   = $clog2(STK_DEPTH);

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_MISS   = 3'd1,
		ST_EXISTS = 3'd2,
		ST_FULL   = 3'd3,
		ST_BADLEN = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] key;
		logic [5:0]  prefix_len;
		logic [31:0] data_in;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] data_out;
	} rsp_t;

	typedef struct packed {
		logic                          valid;
		logic [DATA_BITS-1:0]          data;
		logic [1:0]                    has_kid;
		logic [1:0][IDX_BITS-1:0]      kid;
	} node_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] idx;
		logic [1:0]          ph;
	} stk_ent_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_INIT_STEP,
		DP_LATCH,
		DP_RD_ROOT,
		DP_LK_STEP,
		DP_FL_RD,
		DP_RT_ALLOC,
		DP_LOAD,
		DP_DESCEND,
		DP_SETVALID,
		DP_LINK,
		DP_ZERO,
		DP_DL_HIT,
		DP_PR_PUSH,
		DP_PR_SKIP,
		DP_PR_DECIDE,
		DP_PR_POP,
		DP_PR_LD,
		DP_PR_ROOTCLR,
		DP_PR_RDPAR,
		DP_PR_PARWR
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    fin;
		status_t st;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       init_last;
		logic       rootp;
		logic       badlen;
		logic       fcnt_zero;
		logic       at_plen;
		logic       at_end;
		logic       kid_rd;
		logic       hit_now;
		logic       kid_nq;
		logic       valid_nq;
		logic       ph_two;
		logic       kid_ph;
		logic       sp_zero;
		logic       removed;
		logic       at_root;
	} sts_t;

endpackage

// ===== design/btp_ctrl.sv =====
// Controller state machine of the binary trie prefix table.
module btp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  btp_pkg::sts_t  sts,
	output btp_pkg::cmd_t  cmd,
	output logic           busy
);

	typedef enum logic [15:0] {
		S_INIT     = 16'h0001,
		S_IDLE     = 16'h0002,
		S_DISP     = 16'h0004,
		S_LK_WALK  = 16'h0008,
		S_RT_ALLOC = 16'h0010,
		S_AD_LD    = 16'h0020,
		S_AD_EV    = 16'h0040,
		S_AD_ALLOC = 16'h0080,
		S_AD_ZERO  = 16'h0100,
		S_DL_LD    = 16'h0200,
		S_DL_EV    = 16'h0400,
		S_PR_EV    = 16'h0800,
		S_PR_POP   = 16'h1000,
		S_PR_LD    = 16'h2000,
		S_PR_FIN   = 16'h4000,
		S_PR_FLD   = 16'h8000
	} state_t;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_n = state_q;
		cmd.op  = btp_pkg::DP_NOP;
		cmd.fin = 1'b0;
		cmd.st  = btp_pkg::ST_MISS;
		unique case (state_q)
			S_INIT: begin
				cmd.op = btp_pkg::DP_INIT_STEP;
				if (sts.init_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.op  = btp_pkg::DP_LATCH;
					state_n = S_DISP;
				end
			end
			S_DISP: begin
				priority if (sts.op == btp_pkg::OP_LOOKUP) begin
					if (!sts.rootp) begin
						cmd.fin = 1'b1;
						state_n = S_IDLE;
					end else begin
						cmd.op  = btp_pkg::DP_RD_ROOT;
						state_n = S_LK_WALK;
					end
				end else if (sts.op == btp_pkg::OP_ADD) begin
					priority if (sts.badlen) begin
						cmd.fin = 1'b1;
						cmd.st  = btp_pkg::ST_BADLEN;
						state_n = S_IDLE;
					end else if (!sts.rootp && sts.fcnt_zero) begin
						cmd.fin = 1'b1;
						cmd.st  = btp_pkg::ST_FULL;
						state_n = S_IDLE;
					end else if (!sts.rootp) begin
						cmd.op  = btp_pkg::DP_FL_RD;
						state_n = S_RT_ALLOC;
					end else begin
						cmd.op  = btp_pkg::DP_RD_ROOT;
						state_n = S_AD_LD;
					end
				end else if (sts.op == btp_pkg::OP_DELETE) begin
					priority if (sts.badlen) begin
						cmd.fin = 1'b1;
						cmd.st  = btp_pkg::ST_BADLEN;
						state_n = S_IDLE;
					end else if (!sts.rootp) begin
						cmd.fin = 1'b1;
						state_n = S_IDLE;
					end else begin
						cmd.op  = btp_pkg::DP_RD_ROOT;
						state_n = S_DL_LD;
					end
				end else begin
					cmd.fin = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_LK_WALK: begin
				cmd.op = btp_pkg::DP_LK_STEP;
				if (sts.at_end || !sts.kid_rd) begin
					cmd.fin = 1'b1;
					cmd.st  = sts.hit_now ? btp_pkg::ST_OK : btp_pkg::ST_MISS;
					state_n = S_IDLE;
				end
			end
			S_RT_ALLOC: begin
				cmd.op  = btp_pkg::DP_RT_ALLOC;
				state_n = S_AD_EV;
			end
			S_AD_LD: begin
				cmd.op  = btp_pkg::DP_LOAD;
				state_n = S_AD_EV;
			end
			S_AD_EV: begin
				priority if (sts.at_plen && sts.valid_nq) begin
					cmd.fin = 1'b1;
					cmd.st  = btp_pkg::ST_EXISTS;
					state_n = S_IDLE;
				end else if (sts.at_plen) begin
					cmd.op  = btp_pkg::DP_SETVALID;
					cmd.fin = 1'b1;
					cmd.st  = btp_pkg::ST_OK;
					state_n = S_IDLE;
				end else if (sts.kid_nq) begin
					cmd.op  = btp_pkg::DP_DESCEND;
					state_n = S_AD_LD;
				end else if (sts.fcnt_zero) begin
					cmd.fin = 1'b1;
					cmd.st  = btp_pkg::ST_FULL;
					state_n = S_IDLE;
				end else begin
					cmd.op  = btp_pkg::DP_FL_RD;
					state_n = S_AD_ALLOC;
				end
			end
			S_AD_ALLOC: begin
				cmd.op  = btp_pkg::DP_LINK;
				state_n = S_AD_ZERO;
			end
			S_AD_ZERO: begin
				cmd.op  = btp_pkg::DP_ZERO;
				state_n = S_AD_EV;
			end
			S_DL_LD: begin
				cmd.op  = btp_pkg::DP_LOAD;
				state_n = S_DL_EV;
			end
			S_DL_EV: begin
				priority if (sts.at_plen && sts.valid_nq) begin
					cmd.op  = btp_pkg::DP_DL_HIT;
					state_n = S_PR_EV;
				end else if (!sts.at_plen && sts.kid_nq) begin
					cmd.op  = btp_pkg::DP_DESCEND;
					state_n = S_DL_LD;
				end else begin
					cmd.fin = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_PR_EV: begin
				priority if (!sts.ph_two && sts.kid_ph) begin
					cmd.op  = btp_pkg::DP_PR_PUSH;
					state_n = S_PR_LD;
				end else if (!sts.ph_two) begin
					cmd.op = btp_pkg::DP_PR_SKIP;
				end else begin
					cmd.op  = btp_pkg::DP_PR_DECIDE;
					state_n = sts.sp_zero ? S_PR_FIN : S_PR_POP;
				end
			end
			S_PR_POP: begin
				cmd.op  = btp_pkg::DP_PR_POP;
				state_n = S_PR_LD;
			end
			S_PR_LD: begin
				cmd.op  = btp_pkg::DP_PR_LD;
				state_n = S_PR_EV;
			end
			S_PR_FIN: begin
				priority if (sts.removed && !sts.at_root) begin
					cmd.op  = btp_pkg::DP_PR_RDPAR;
					state_n = S_PR_FLD;
				end else begin
					if (sts.removed) cmd.op = btp_pkg::DP_PR_ROOTCLR;
					cmd.fin = 1'b1;
					cmd.st  = btp_pkg::ST_OK;
					state_n = S_IDLE;
				end
			end
			S_PR_FLD: begin
				cmd.op  = btp_pkg::DP_PR_PARWR;
				cmd.fin = 1'b1;
				cmd.st  = btp_pkg::ST_OK;
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_INIT;
			end
		endcase
	end

endmodule

// ===== design/btp_dp.sv =====
// Datapath of the binary trie prefix table: node pool, free list, prune stack.
module btp_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  btp_pkg::req_t  req,
	input  btp_pkg::cmd_t  cmd,
	output btp_pkg::sts_t  sts,
	output logic           done,
	output btp_pkg::rsp_t  rsp
);

	localparam int IB = btp_pkg::IDX_BITS;
	localparam int CB = btp_pkg::CNT_BITS;
	localparam int DB = btp_pkg::DEPTH_BITS;
	localparam int SB = btp_pkg::STK_BITS;

	btp_pkg::node_t    node_mem [btp_pkg::NODE_COUNT];
	logic [IB-1:0]     fl_mem   [btp_pkg::NODE_COUNT];
	btp_pkg::stk_ent_t stk_mem  [btp_pkg::STK_DEPTH];

	btp_pkg::node_t    rd_q, node_q;
	logic [IB-1:0]     fl_rd_q;
	btp_pkg::stk_ent_t stk_rd_q;

	logic [CB-1:0]     fcnt_q;
	logic [IB-1:0]     root_q, ini_q;
	logic              rootp_q;
	logic [SB:0]       sp_q;
	logic              done_q;
	btp_pkg::rsp_t     rsp_q;

	logic [1:0]                  op_q;
	logic [31:0]                 key_q;
	logic [5:0]                  plen_q;
	logic [btp_pkg::DATA_BITS-1:0] din_q, best_q, dout_q;
	logic [DB-1:0]               d_q;
	logic                        hit_q, at_root_q, pside_q, removed_q;
	logic [IB-1:0]               cur_q, parent_q, new_q, top_idx_q;
	logic [1:0]                  top_ph_q;

	logic                        b, ret_side, rem_now, hit_now;
	logic [btp_pkg::DATA_BITS-1:0] best_now;
	btp_pkg::node_t              pr_mod, par_mod, link_mod, nw_data;
	logic                        nw_en;
	logic [IB-1:0]               nw_addr, nr_addr, fl_waddr, fl_wdata, fl_raddr;
	logic                        fl_we;

	assign b        = key_q[5'(btp_pkg::KEY_BITS - 1) - d_q[4:0]];
	assign ret_side = top_ph_q[1];
	assign rem_now  = !node_q.has_kid[0] && !node_q.has_kid[1] && !node_q.valid;
	assign hit_now  = hit_q | rd_q.valid;
	assign best_now = rd_q.valid ? rd_q.data : best_q;
	assign fl_raddr = IB'(fcnt_q - CB'(1));

	always_comb begin
		pr_mod = rd_q;
		if (removed_q) begin
			pr_mod.has_kid[ret_side] = 1'b0;
			pr_mod.kid[ret_side]     = '0;
		end
		par_mod = rd_q;
		par_mod.has_kid[pside_q] = 1'b0;
		par_mod.kid[pside_q]     = '0;
		link_mod = node_q;
		link_mod.has_kid[b] = 1'b1;
		link_mod.kid[b]     = fl_rd_q;
	end

	always_comb begin
		nw_en   = 1'b0;
		nw_addr = cur_q;
		nw_data = '0;
		nr_addr = cur_q;
		fl_we    = 1'b0;
		fl_waddr = ini_q;
		fl_wdata = ini_q;
		unique case (cmd.op)
			btp_pkg::DP_INIT_STEP: fl_we = 1'b1;
			btp_pkg::DP_RD_ROOT:   nr_addr = root_q;
			btp_pkg::DP_LK_STEP:   nr_addr = rd_q.kid[b];
			btp_pkg::DP_DESCEND:   nr_addr = node_q.kid[b];
			btp_pkg::DP_RT_ALLOC: begin
				nw_en   = 1'b1;
				nw_addr = fl_rd_q;
			end
			btp_pkg::DP_SETVALID: begin
				nw_en        = 1'b1;
				nw_data      = node_q;
				nw_data.valid = 1'b1;
				nw_data.data  = din_q;
			end
			btp_pkg::DP_LINK: begin
				nw_en   = 1'b1;
				nw_data = link_mod;
			end
			btp_pkg::DP_ZERO: begin
				nw_en   = 1'b1;
				nw_addr = new_q;
			end
			btp_pkg::DP_DL_HIT: begin
				nw_en         = 1'b1;
				nw_data       = node_q;
				nw_data.valid = 1'b0;
				nw_data.data  = '0;
			end
			btp_pkg::DP_PR_PUSH:   nr_addr = node_q.kid[top_ph_q[0]];
			btp_pkg::DP_PR_DECIDE: begin
				fl_we    = rem_now;
				fl_waddr = fcnt_q[IB-1:0];
				fl_wdata = top_idx_q;
			end
			btp_pkg::DP_PR_POP:    nr_addr = stk_rd_q.idx;
			btp_pkg::DP_PR_LD: begin
				nw_en   = removed_q;
				nw_addr = top_idx_q;
				nw_data = pr_mod;
			end
			btp_pkg::DP_PR_RDPAR:  nr_addr = parent_q;
			btp_pkg::DP_PR_PARWR: begin
				nw_en   = 1'b1;
				nw_addr = parent_q;
				nw_data = par_mod;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nw_en) node_mem[nw_addr] <= nw_data;
		rd_q <= node_mem[nr_addr];
	end

	always_ff @(posedge clk) begin
		if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
		fl_rd_q <= fl_mem[fl_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == btp_pkg::DP_PR_PUSH) begin
			stk_mem[sp_q[SB-1:0]] <= '{idx: top_idx_q, ph: top_ph_q + 2'd1};
		end
		stk_rd_q <= stk_mem[SB'(sp_q - (SB+1)'(1))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q  <= CB'(btp_pkg::NODE_COUNT);
			root_q  <= '0;
			rootp_q <= 1'b0;
			sp_q    <= '0;
			ini_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			unique case (cmd.op)
				btp_pkg::DP_INIT_STEP: ini_q <= ini_q + IB'(1);
				btp_pkg::DP_LATCH:     sp_q  <= '0;
				btp_pkg::DP_RT_ALLOC: begin
					fcnt_q  <= fcnt_q - CB'(1);
					root_q  <= fl_rd_q;
					rootp_q <= 1'b1;
				end
				btp_pkg::DP_LINK:      fcnt_q <= fcnt_q - CB'(1);
				btp_pkg::DP_PR_PUSH:   sp_q   <= sp_q + (SB+1)'(1);
				btp_pkg::DP_PR_DECIDE: begin
					if (rem_now) fcnt_q <= fcnt_q + CB'(1);
					if (sp_q != '0) sp_q <= sp_q - (SB+1)'(1);
				end
				btp_pkg::DP_PR_ROOTCLR: begin
					rootp_q <= 1'b0;
					root_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_q.status   <= cmd.st;
			rsp_q.data_out <= (cmd.op == btp_pkg::DP_LK_STEP) ? best_now : dout_q;
		end
		unique case (cmd.op)
			btp_pkg::DP_LATCH: begin
				op_q      <= req.op;
				key_q     <= req.key;
				plen_q    <= req.prefix_len;
				din_q     <= req.data_in[btp_pkg::DATA_BITS-1:0];
				d_q       <= '0;
				hit_q     <= 1'b0;
				best_q    <= '0;
				dout_q    <= '0;
				at_root_q <= 1'b1;
			end
			btp_pkg::DP_RD_ROOT: cur_q <= root_q;
			btp_pkg::DP_LK_STEP: begin
				hit_q  <= hit_now;
				best_q <= best_now;
				cur_q  <= rd_q.kid[b];
				d_q    <= d_q + DB'(1);
			end
			btp_pkg::DP_RT_ALLOC: begin
				cur_q  <= fl_rd_q;
				node_q <= '0;
			end
			btp_pkg::DP_LOAD: node_q <= rd_q;
			btp_pkg::DP_DESCEND: begin
				parent_q  <= cur_q;
				pside_q   <= b;
				at_root_q <= 1'b0;
				cur_q     <= node_q.kid[b];
				d_q       <= d_q + DB'(1);
			end
			btp_pkg::DP_LINK: new_q <= fl_rd_q;
			btp_pkg::DP_ZERO: begin
				cur_q  <= new_q;
				node_q <= '0;
				d_q    <= d_q + DB'(1);
			end
			btp_pkg::DP_DL_HIT: begin
				dout_q       <= node_q.data;
				node_q.valid <= 1'b0;
				node_q.data  <= '0;
				top_idx_q    <= cur_q;
				top_ph_q     <= 2'd0;
				removed_q    <= 1'b0;
			end
			btp_pkg::DP_PR_PUSH: begin
				top_idx_q <= node_q.kid[top_ph_q[0]];
				top_ph_q  <= 2'd0;
				removed_q <= 1'b0;
			end
			btp_pkg::DP_PR_SKIP:   top_ph_q  <= top_ph_q + 2'd1;
			btp_pkg::DP_PR_DECIDE: removed_q <= rem_now;
			btp_pkg::DP_PR_POP: begin
				top_idx_q <= stk_rd_q.idx;
				top_ph_q  <= stk_rd_q.ph;
			end
			btp_pkg::DP_PR_LD: begin
				node_q    <= pr_mod;
				removed_q <= 1'b0;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.op        = op_q;
		sts.init_last = (ini_q == IB'(btp_pkg::NODE_COUNT - 1));
		sts.rootp     = rootp_q;
		sts.badlen    = (plen_q > 6'(btp_pkg::KEY_BITS));
		sts.fcnt_zero = (fcnt_q == '0);
		sts.at_plen   = (d_q == DB'(plen_q));
		sts.at_end    = (d_q >= DB'(btp_pkg::KEY_BITS));
		sts.kid_rd    = rd_q.has_kid[b];
		sts.hit_now   = hit_now;
		sts.kid_nq    = node_q.has_kid[b];
		sts.valid_nq  = node_q.valid;
		sts.ph_two    = top_ph_q[1];
		sts.kid_ph    = node_q.has_kid[top_ph_q[0]];
		sts.sp_zero   = (sp_q == '0);
		sts.removed   = removed_q;
		sts.at_root   = at_root_q;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== design/binary_trie_prefix_table_unit.sv =====
// Top level of the binary trie prefix table.
// Commands (lookup, add, delete) are taken when start is high and busy is low; each gives
// one result on rsp for a single cycle with done high, and it cannot be held off.
// After reset the free list is loaded, one entry per cycle, while busy stays high.
// Every trie level costs one node-memory read. A delete then prunes the removed node's
// subtree depth first and, if the node itself is freed, unlinks it from its parent
// or clears the root.
module binary_trie_prefix_table_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  btp_pkg::req_t  req,
	output logic           done,
	output btp_pkg::rsp_t  rsp
);

	btp_pkg::cmd_t cmd;
	btp_pkg::sts_t sts;

	btp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	btp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ===== design/btp_chk.sv =====
// Port-level assertions for the binary trie prefix table, bound to the top level.
module btp_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input btp_pkg::rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status <= btp_pkg::ST_BADLEN)
		else $error("status code out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != btp_pkg::ST_OK |-> rsp.data_out == '0)
		else $error("failed item returned nonzero data");

endmodule

bind binary_trie_prefix_table_unit btp_chk u_btp_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

// ===== tb/sv/binary_trie_prefix_table_unit_tb.sv =====
// Testbench for the binary trie prefix table: directed and random commands checked against a trie model.
module binary_trie_prefix_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		bit          valid;
		bit [31:0]   data;
		bit [1:0]    has_kid;
		int unsigned kid [2];
	} tnode_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	btp_pkg::req_t  req = '0;
	logic           busy, done;
	btp_pkg::rsp_t  rsp;

	tnode_t          pool [btp_pkg::NODE_COUNT];
	int unsigned     free_stk [btp_pkg::NODE_COUNT];
	int unsigned     free_cnt;
	int unsigned     root_idx;
	bit              root_ok;
	btp_pkg::rsp_t   expected_rsps [$];
	int              err_count = 0;
	int              idle_pct = 14;
	bit [31:0]       used_keys [$];
	bit [5:0]        used_lens [$];

	binary_trie_prefix_table_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #1 clk = ~clk;

	initial begin
		#40_000_000;
		$display("binary_trie_prefix_table_unit_tb: done, errors");
		$finish;
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic int unsigned kbit(bit [31:0] k, int unsigned d);
		return k[btp_pkg::KEY_BITS - 1 - d];
	endfunction

	function automatic bit take_node(output int unsigned idx);
		if (free_cnt == 0)
			return 0;
		free_cnt--;
		idx = free_stk[free_cnt];
		pool[idx] = '{0, 0, 2'b00, '{0, 0}};
		return 1;
	endfunction

	function automatic bit keep_subtree(int unsigned n, int unsigned d);
		if (d > btp_pkg::KEY_BITS + 1)
			return 1;
		for (int s = 0; s < 2; s++) begin
			if (pool[n].has_kid[s] && !keep_subtree(pool[n].kid[s], d + 1)) begin
				pool[n].has_kid[s] = 0;
				pool[n].kid[s] = 0;
			end
		end
		if (pool[n].has_kid == 2'b00 && !pool[n].valid) begin
			if (free_cnt < btp_pkg::NODE_COUNT) begin
				free_stk[free_cnt] = n;
				free_cnt++;
			end
			return 0;
		end
		return 1;
	endfunction

	function automatic btp_pkg::rsp_t trie_apply(btp_pkg::req_t r);
		btp_pkg::rsp_t o;
		int unsigned   cur, nn, par, pside, d;
		bit            ok, hit, at_root;
		o.status = btp_pkg::ST_MISS;
		o.data_out = '0;
		if (r.op == btp_pkg::OP_LOOKUP) begin
			if (root_ok) begin
				hit = 0;
				cur = root_idx;
				for (d = 0; ; d++) begin
					if (pool[cur].valid) begin
						hit = 1;
						o.data_out = pool[cur].data;
					end
					if (d >= btp_pkg::KEY_BITS || !pool[cur].has_kid[kbit(r.key, d)])
						break;
					cur = pool[cur].kid[kbit(r.key, d)];
				end
				if (hit)
					o.status = btp_pkg::ST_OK;
			end
		end else if (r.op == btp_pkg::OP_ADD) begin
			if (r.prefix_len > btp_pkg::KEY_BITS) begin
				o.status = btp_pkg::ST_BADLEN;
			end else begin
				ok = 1;
				if (!root_ok) begin
					if (take_node(nn)) begin
						root_idx = nn;
						root_ok = 1;
					end else begin
						ok = 0;
					end
				end
				cur = root_idx;
				for (d = 0; ok && d < r.prefix_len; d++) begin
					if (!pool[cur].has_kid[kbit(r.key, d)]) begin
						if (!take_node(nn)) begin
							ok = 0;
							break;
						end
						pool[cur].has_kid[kbit(r.key, d)] = 1;
						pool[cur].kid[kbit(r.key, d)] = nn;
					end
					cur = pool[cur].kid[kbit(r.key, d)];
				end
				if (!ok)
					o.status = btp_pkg::ST_FULL;
				else if (pool[cur].valid)
					o.status = btp_pkg::ST_EXISTS;
				else begin
					pool[cur].valid = 1;
					pool[cur].data = r.data_in;
					o.status = btp_pkg::ST_OK;
				end
			end
		end else if (r.op == btp_pkg::OP_DELETE) begin
			if (r.prefix_len > btp_pkg::KEY_BITS) begin
				o.status = btp_pkg::ST_BADLEN;
			end else if (root_ok) begin
				ok = 1;
				at_root = 1;
				par = 0;
				pside = 0;
				cur = root_idx;
				for (d = 0; d < r.prefix_len; d++) begin
					if (!pool[cur].has_kid[kbit(r.key, d)]) begin
						ok = 0;
						break;
					end
					par = cur;
					pside = kbit(r.key, d);
					at_root = 0;
					cur = pool[cur].kid[pside];
				end
				if (ok && pool[cur].valid) begin
					o.data_out = pool[cur].data;
					pool[cur].valid = 0;
					pool[cur].data = 0;
					o.status = btp_pkg::ST_OK;
					if (!keep_subtree(cur, d)) begin
						if (at_root) begin
							root_ok = 0;
							root_idx = 0;
						end else begin
							pool[par].has_kid[pside] = 0;
							pool[par].kid[pside] = 0;
						end
					end
				end
			end
		end
		return o;
	endfunction

	always @(posedge clk) begin
		btp_pkg::rsp_t exp_r;
		if (done) begin
			if (expected_rsps.size() == 0) begin
				report($sformatf("unexpected result %0d/%h", rsp.status, rsp.data_out));
			end else begin
				exp_r = expected_rsps.pop_front();
				if (rsp.status !== exp_r.status)
					report($sformatf("status %0d, want %0d", rsp.status, exp_r.status));
				if (rsp.data_out !== exp_r.data_out)
					report($sformatf("data_out %h, want %h", rsp.data_out, exp_r.data_out));
			end
		end
	end

	task automatic send_cmd(input logic [1:0] op, input bit [31:0] key,
			input bit [5:0] plen, input bit [31:0] din);
		btp_pkg::req_t r;
		r = '{op: op, key: key, prefix_len: plen, data_in: din};
		while ($urandom_range(99) < idle_pct) begin
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_rsps.push_back(trie_apply(r));
		if (op == btp_pkg::OP_ADD) begin
			used_keys.push_back(key);
			used_lens.push_back(plen);
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_cmd(btp_pkg::OP_LOOKUP, 32'h0, 6'd0, 32'h0);
		send_cmd(btp_pkg::OP_DELETE, 32'h0, 6'd0, 32'h0);
		send_cmd(btp_pkg::OP_ADD, 32'h0, 6'd0, 32'hFFFF_FFFF);
		send_cmd(btp_pkg::OP_ADD, 32'h0, 6'd0, 32'h1);
		send_cmd(btp_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd32, 32'hA5A5_5A5A);
		send_cmd(btp_pkg::OP_ADD, 32'h8000_0000, 6'd1, 32'h1111);
		send_cmd(btp_pkg::OP_ADD, 32'h0, 6'd32, 32'h2222);
		send_cmd(btp_pkg::OP_ADD, 32'h1234_5678, 6'd33, 32'h3);
		send_cmd(btp_pkg::OP_ADD, 32'h1234_5678, 6'd63, 32'h3);
		send_cmd(btp_pkg::OP_DELETE, 32'h1234_5678, 6'd63, 32'h0);
		send_cmd(btp_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
		send_cmd(btp_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 6'd0, 32'h0);
		send_cmd(btp_pkg::OP_LOOKUP, 32'h0, 6'd0, 32'h0);
		send_cmd(btp_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 6'd0, 32'h0);
		send_cmd(OP_UNUSED, 32'hFFFF_FFFF, 6'd5, 32'h9);
		send_cmd(btp_pkg::OP_DELETE, 32'hFFFF_FFFF, 6'd16, 32'h0);
		send_cmd(btp_pkg::OP_DELETE, 32'h8000_0000, 6'd1, 32'hFFFF_FFFF);
		send_cmd(btp_pkg::OP_DELETE, 32'h0, 6'd0, 32'h0);
		send_cmd(btp_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
		send_cmd(btp_pkg::OP_DELETE, 32'hFFFF_FFFF, 6'd32, 32'h0);
		send_cmd(btp_pkg::OP_DELETE, 32'h0, 6'd32, 32'h0);
		send_cmd(btp_pkg::OP_LOOKUP, 32'h0, 6'd0, 32'h0);
		drain();
	endtask

	// random 32-bit prefixes until the pool runs out, then free them
	task automatic test_pool_full();
		bit [31:0] k;
		for (int i = 0; i < 36; i++) begin
			k = $urandom();
			send_cmd(btp_pkg::OP_ADD, k, 6'd32, $urandom());
		end
		send_cmd(btp_pkg::OP_LOOKUP, k, 6'd0, 32'h0);
		for (int i = 0; i < 36 && used_keys.size() != 0; i++)
			send_cmd(btp_pkg::OP_DELETE, used_keys.pop_back(), used_lens.pop_back(), 32'h0);
		send_cmd(btp_pkg::OP_DELETE, 32'h0, 6'd0, 32'h0);
		drain();
		used_keys.delete();
		used_lens.delete();
	endtask

	task automatic test_random(input int n);
		bit [31:0] k;
		bit [5:0]  l;
		int        sel, pick;
		for (int i = 0; i < n; i++) begin
			idle_pct = (i >= n / 3 && i < n / 2) ? 0 : 14;
			sel = $urandom_range(99);
			pick = used_keys.size();
			if (pick != 0 && sel < 55) begin
				pick = $urandom_range(used_keys.size() - 1);
				k = used_keys[pick] ^ ($urandom_range(3) == 0 ? $urandom() : 32'h0);
				l = used_lens[pick];
			end else begin
				k = $urandom();
				l = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
			end
			if (used_keys.size() > 200) begin
				used_keys.pop_front();
				used_lens.pop_front();
			end
			sel = $urandom_range(99);
			if (sel < 40)
				send_cmd(btp_pkg::OP_ADD, k, l, $urandom());
			else if (sel < 75)
				send_cmd(btp_pkg::OP_LOOKUP, k, 6'($urandom()), $urandom());
			else if (sel < 97)
				send_cmd(btp_pkg::OP_DELETE, k, l, $urandom());
			else
				send_cmd(OP_UNUSED, k, l, $urandom());
			if (i == n / 4)
				drain();
		end
	endtask

	initial begin
		for (int i = 0; i < btp_pkg::NODE_COUNT; i++) begin
			free_stk[i] = i;
			pool[i] = '{0, 0, 2'b00, '{0, 0}};
		end
		free_cnt = btp_pkg::NODE_COUNT;
		root_idx = 0;
		root_ok = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pool_full();
		test_random(650);
		drain();
		repeat (200) @(posedge clk);
		if (err_count == 0)
			$display("binary_trie_prefix_table_unit_tb: done, clean");
		else
			$display("binary_trie_prefix_table_unit_tb: done, errors");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/btp_pkg.sv
design/btp_ctrl.sv
design/btp_dp.sv
design/binary_trie_prefix_table_unit.sv
design/btp_chk.sv
tb/sv/binary_trie_prefix_table_unit_tb.sv
